@@ hw/rtl/hlpd_pkg.sv @@
`default_nettype none

package hlpd_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PAYLOAD  = 3'd0;
    localparam kind_t KIND_HS_OK    = 3'd1;
    localparam kind_t KIND_EMPTY    = 3'd2;
    localparam kind_t KIND_HS_BAD   = 3'd3;
    localparam kind_t KIND_OVER     = 3'd4;
    localparam kind_t KIND_DIGIT    = 3'd5;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_HANDSHAKE_BYTES  = 2'd0;
    localparam reg_index_t REG_HANDSHAKE_LENGTH = 2'd1;
    localparam reg_index_t REG_SIZE_LIMIT       = 2'd2;

    localparam int CFG_DATA_W    = 64;
    localparam int HS_LEN_W      = 4;
    localparam int SIZE_LIMIT_W  = 32;

    localparam logic [SIZE_LIMIT_W-1:0] SIZE_LIMIT_RESET = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/handshake_length_prefixed_deframer_top.sv @@
`default_nettype none

// Channel   Direction  Signals                         Contents
// s_*       in         s_tvalid s_tready s_tdata       received byte
// m_*       out        m_tvalid m_tready m_tdata/tuser payload byte, kind, tlast on final byte
// cfg_*     in         cfg_we cfg_index cfg_data       handshake bytes, length, size limit
//
// One byte is taken per cycle while s_tready is high; each item's result is registered in the output stage.
// The per-byte step is a single compare or a shift-add by ten and a limit compare.
// A two-entry output stage (result register plus skid register) keeps s_tready high
// under downstream stall until both entries fill; s_tready drops only when both are full.
// rst_n clears the control state and valid flags and loads register reset values; no clearing pass is needed.
module handshake_length_prefixed_deframer_top #(
    parameter int HANDSHAKE_MAX_BYTES = 8,
    parameter int LENGTH_BITS         = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] payload
    output logic [2:0]                           m_tuser,   // [2:0] kind
    output logic                                 m_tlast,

    input  wire logic                            cfg_we,
    input  wire hlpd_pkg::reg_index_t            cfg_index,
    input  wire logic [hlpd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int HS_W   = 8 * HANDSHAKE_MAX_BYTES;
    localparam int CMP_W  = (LENGTH_BITS > hlpd_pkg::SIZE_LIMIT_W) ?
                            LENGTH_BITS : hlpd_pkg::SIZE_LIMIT_W;
    localparam int NEXT_W = LENGTH_BITS + 4;
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'({LENGTH_BITS{1'b1}});
    localparam logic [hlpd_pkg::HS_LEN_W-1:0] HS_MAX =
        hlpd_pkg::HS_LEN_W'(HANDSHAKE_MAX_BYTES);

    typedef enum logic [1:0] {
        PH_HANDSHAKE = 2'd0,
        PH_SIZE      = 2'd1,
        PH_MESSAGE   = 2'd2,
        PH_ERROR     = 2'd3
    } phase_t;

    // Configuration registers
    logic [HS_W-1:0]                       hs_bytes_reg;
    logic [hlpd_pkg::HS_LEN_W-1:0]         hs_len_reg;
    logic [hlpd_pkg::SIZE_LIMIT_W-1:0]     size_limit_reg;

    // Deframer state
    phase_t                                phase_reg, phase_next;
    logic [3:0]                            pos_reg, pos_next;
    logic                                  mismatch_reg, mismatch_next;
    logic [LENGTH_BITS-1:0]                acc_reg, acc_next;
    logic                                  over_reg, over_next;
    logic [LENGTH_BITS-1:0]                rem_reg, rem_next;

    // Output stage
    logic                                  out_valid_reg;
    hlpd_pkg::result_t                     out_reg;
    logic                                  skid_valid_reg;
    hlpd_pkg::result_t                     skid_reg;

    logic                                  in_accept;
    logic                                  out_take;
    logic                                  res_valid;
    hlpd_pkg::result_t                     res;

    // Size-line step, shared by the size phase and a skipped handshake
    logic [CMP_W-1:0]                      limit_wide;
    logic [LENGTH_BITS-1:0]                eff_limit;
    logic                                  is_digit;
    logic [NEXT_W-1:0]                     acc_times_ten;
    logic                                  sz_valid;
    hlpd_pkg::kind_t                       sz_kind;
    phase_t                                sz_phase;
    logic [LENGTH_BITS-1:0]                sz_acc;
    logic                                  sz_over;
    logic [LENGTH_BITS-1:0]                sz_rem;

    // Handshake step
    logic [hlpd_pkg::HS_LEN_W-1:0]         hs_len_eff;
    logic [7:0]                            hs_expect;
    logic [3:0]                            pos_inc;
    logic                                  hs_miss;

    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;
    assign s_tready  = !skid_valid_reg;

    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.kind;
    assign m_tdata   = out_reg.payload;
    assign m_tlast   = out_reg.last;

    always_comb
    begin
        limit_wide    = CMP_W'(size_limit_reg);
        if (limit_wide > LEN_MAX)
        begin
            limit_wide = LEN_MAX;
        end
        eff_limit     = LENGTH_BITS'(limit_wide);
        is_digit      = (s_tdata >= hlpd_pkg::CHAR_ZERO) && (s_tdata <= hlpd_pkg::CHAR_NINE);
        acc_times_ten = (NEXT_W'(acc_reg) << 3) + (NEXT_W'(acc_reg) << 1)
                        + NEXT_W'(s_tdata[3:0]);

        sz_valid = 1'b0;
        sz_kind  = hlpd_pkg::KIND_PAYLOAD;
        sz_phase = PH_SIZE;
        sz_acc   = acc_reg;
        sz_over  = over_reg;
        sz_rem   = rem_reg;

        if (s_tdata == hlpd_pkg::CHAR_NEWLINE)
        begin
            if (over_reg)
            begin
                sz_valid = 1'b1;
                sz_kind  = hlpd_pkg::KIND_OVER;
                sz_phase = PH_ERROR;
            end
            else if (acc_reg == '0)
            begin
                sz_valid = 1'b1;
                sz_kind  = hlpd_pkg::KIND_EMPTY;
            end
            else
            begin
                sz_rem   = acc_reg;
                sz_acc   = '0;
                sz_phase = PH_MESSAGE;
            end
        end
        else if (!is_digit)
        begin
            sz_valid = 1'b1;
            sz_kind  = hlpd_pkg::KIND_DIGIT;
            sz_phase = PH_ERROR;
        end
        else if (!over_reg)
        begin
            // The accumulator freezes once a digit would take it past the limit.
            if (acc_times_ten > NEXT_W'(eff_limit))
            begin
                sz_over = 1'b1;
            end
            else
            begin
                sz_acc = LENGTH_BITS'(acc_times_ten);
            end
        end
    end

    always_comb
    begin
        hs_len_eff = (hs_len_reg > HS_MAX) ? HS_MAX : hs_len_reg;
        hs_expect  = 8'(hs_bytes_reg >> (6'(pos_reg[2:0]) << 3));
        pos_inc    = {1'b0, pos_reg[2:0]} + 4'd1;
        hs_miss    = mismatch_reg || (hs_expect != s_tdata);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        acc_next      = acc_reg;
        over_next     = over_reg;
        rem_next      = rem_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (in_accept)
        begin
            case (phase_reg)
                PH_HANDSHAKE:
                begin
                    if (hs_len_eff == '0)
                    begin
                        // No handshake configured: the byte belongs to the size line.
                        pos_next      = '0;
                        mismatch_next = 1'b0;
                        phase_next    = sz_phase;
                        acc_next      = sz_acc;
                        over_next     = sz_over;
                        rem_next      = sz_rem;
                        res_valid     = sz_valid;
                        res.kind      = sz_kind;
                    end
                    else
                    begin
                        pos_next      = pos_inc;
                        mismatch_next = hs_miss;
                        if (pos_inc >= hs_len_eff)
                        begin
                            res_valid = 1'b1;
                            if (hs_miss)
                            begin
                                res.kind   = hlpd_pkg::KIND_HS_BAD;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                res.kind   = hlpd_pkg::KIND_HS_OK;
                                phase_next = PH_SIZE;
                            end
                        end
                    end
                end
                PH_SIZE:
                begin
                    phase_next = sz_phase;
                    acc_next   = sz_acc;
                    over_next  = sz_over;
                    rem_next   = sz_rem;
                    res_valid  = sz_valid;
                    res.kind   = sz_kind;
                end
                PH_MESSAGE:
                begin
                    res_valid   = 1'b1;
                    res.kind    = hlpd_pkg::KIND_PAYLOAD;
                    res.payload = s_tdata;
                    if (rem_reg <= LENGTH_BITS'(1))
                    begin
                        res.last   = 1'b1;
                        rem_next   = '0;
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        rem_next = rem_reg - LENGTH_BITS'(1);
                    end
                end
                PH_ERROR:
                begin
                    // Sticky: bytes are consumed without a result.
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_bytes_reg   <= '0;
            hs_len_reg     <= '0;
            size_limit_reg <= hlpd_pkg::SIZE_LIMIT_RESET;
            phase_reg      <= PH_HANDSHAKE;
            pos_reg        <= '0;
            mismatch_reg   <= 1'b0;
            acc_reg        <= '0;
            over_reg       <= 1'b0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hlpd_pkg::REG_HANDSHAKE_BYTES:
                    begin
                        hs_bytes_reg <= HS_W'(cfg_data);
                    end
                    hlpd_pkg::REG_HANDSHAKE_LENGTH:
                    begin
                        hs_len_reg <= cfg_data[hlpd_pkg::HS_LEN_W-1:0];
                    end
                    hlpd_pkg::REG_SIZE_LIMIT:
                    begin
                        size_limit_reg <= cfg_data[hlpd_pkg::SIZE_LIMIT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            acc_reg      <= acc_next;
            over_reg     <= over_next;
            rem_reg      <= rem_next;

            // While the skid entry is full no item is accepted, so only draining happens.
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
